@@ hw/rtl/mhdset_pkg.sv @@
`timescale 1ns / 1ps
// Package with widths, constants, register indexes and selection helpers for the MHD tensor block.
package mhdset_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int MET_WIDTH  = 18;
    localparam int CFG_IDX_W  = 2;
    localparam int IDX_W      = 2;
    localparam int COMP_W     = 2 * IDX_W;

    localparam logic [COMP_W-1:0] COMP_LAST = {COMP_W{1'b1}};

    localparam int SPLIT_W   = 32;
    localparam int PROD_W    = 2 * DATA_WIDTH;
    localparam int PTOT_W    = DATA_WIDTH + 1;
    localparam int HTOT_W    = PROD_W - FRAC_BITS;
    localparam int HTOT_HI_W = HTOT_W - SPLIT_W;
    localparam int HP_HI_W   = HTOT_HI_W + DATA_WIDTH;
    localparam int HP_LO_W   = SPLIT_W + 1 + DATA_WIDTH;
    localparam int HPF_W     = HTOT_W + DATA_WIDTH;
    localparam int HU_W      = HPF_W - FRAC_BITS;
    localparam int HU_HI_W   = HU_W - SPLIT_W;
    localparam int Q_HI_W    = HU_HI_W + DATA_WIDTH;
    localparam int Q_LO_W    = SPLIT_W + 1 + DATA_WIDTH;
    localparam int QF_W      = HU_W + DATA_WIDTH;
    localparam int T1W_W     = QF_W - FRAC_BITS;
    localparam int T1_LIM_LOG2 = 50;
    localparam int T1_W      = T1_LIM_LOG2 + 2;
    localparam int T2P_W     = PTOT_W + MET_WIDTH;
    localparam int T2_W      = T2P_W - FRAC_BITS;
    localparam int T3_W      = PROD_W - FRAC_BITS;
    localparam int D_W       = T3_W + 1;
    localparam int V_W       = T1_W + 1;

    localparam logic signed [MET_WIDTH-1:0] MET_POS_ONE =
        MET_WIDTH'({1'b1, {FRAC_BITS{1'b0}}});
    localparam logic signed [MET_WIDTH-1:0] MET_NEG_ONE = -MET_POS_ONE;

    localparam logic signed [T1W_W-1:0] T1_HI = T1W_W'({1'b1, {T1_LIM_LOG2{1'b0}}});
    localparam logic signed [T1W_W-1:0] T1_LO = -T1_HI;

    localparam logic signed [V_W-1:0] OUT_MAX = V_W'({1'b0, {(DATA_WIDTH-1){1'b1}}});
    localparam logic signed [V_W-1:0] OUT_MIN = -OUT_MAX - V_W'(1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_METRIC_T = 2'd0,
        REG_METRIC_X = 2'd1,
        REG_METRIC_Y = 2'd2,
        REG_METRIC_Z = 2'd3
    } cfg_reg_t;

    function automatic logic signed [DATA_WIDTH-1:0] pick_data(
        input logic [IDX_W-1:0]             sel,
        input logic signed [DATA_WIDTH-1:0] a0,
        input logic signed [DATA_WIDTH-1:0] a1,
        input logic signed [DATA_WIDTH-1:0] a2,
        input logic signed [DATA_WIDTH-1:0] a3
    );
        case (sel)
            2'd0:    pick_data = a0;
            2'd1:    pick_data = a1;
            2'd2:    pick_data = a2;
            default: pick_data = a3;
        endcase
    endfunction

    function automatic logic signed [MET_WIDTH-1:0] pick_met(
        input logic [IDX_W-1:0]            sel,
        input logic signed [MET_WIDTH-1:0] a0,
        input logic signed [MET_WIDTH-1:0] a1,
        input logic signed [MET_WIDTH-1:0] a2,
        input logic signed [MET_WIDTH-1:0] a3
    );
        case (sel)
            2'd0:    pick_met = a0;
            2'd1:    pick_met = a1;
            2'd2:    pick_met = a2;
            default: pick_met = a3;
        endcase
    endfunction

endpackage

@@ hw/rtl/mhd_stress_energy_tensor_top.sv @@
`timescale 1ns / 1ps
// Top level of the ideal-MHD stress-energy tensor block with its component pipeline.
//
// Usage: each item on the input channel (in_valid/in_ready) is one fluid cell. The block
// returns its sixteen tensor components T^{mu nu} on the output channel (out_valid/out_ready)
// in row-major order, with last_component high on mu = nu = 3.
// The diagonal of the inverse metric is written through the configuration channel
// (cfg_valid/cfg_ready/cfg_index/cfg_data); cfg_ready is always high.
// The accepted item sits in a holding register while a component counter issues one
// (mu, nu) pair per cycle, unless the receiver stalls, into an eight-stage pipeline of
// multipliers and adders. Throughput: one component per cycle when the receiver does not
// stall; the next item is accepted in the cycle its predecessor issues its last component.
// Reset makes all pipeline stages and the holding register empty and loads the Minkowski
// metric (-1, +1, +1, +1). When the receiver stalls, the whole pipeline holds its contents
// and the holding register stops issuing; nothing is lost or repeated.
module mhd_stress_energy_tensor_top (
    input  logic                                             clk,
    input  logic                                             rst_n,
    input  logic                                             in_valid,
    output logic                                             in_ready,
    input  logic signed [mhdset_pkg::DATA_WIDTH-1:0]         rest_density,
    input  logic signed [mhdset_pkg::DATA_WIDTH-1:0]         gas_pressure,
    input  logic signed [mhdset_pkg::DATA_WIDTH-1:0]         specific_enthalpy,
    input  logic signed [mhdset_pkg::DATA_WIDTH-1:0]         four_vel_t,
    input  logic signed [mhdset_pkg::DATA_WIDTH-1:0]         four_vel_x,
    input  logic signed [mhdset_pkg::DATA_WIDTH-1:0]         four_vel_y,
    input  logic signed [mhdset_pkg::DATA_WIDTH-1:0]         four_vel_z,
    input  logic signed [mhdset_pkg::DATA_WIDTH-1:0]         mag_four_t,
    input  logic signed [mhdset_pkg::DATA_WIDTH-1:0]         mag_four_x,
    input  logic signed [mhdset_pkg::DATA_WIDTH-1:0]         mag_four_y,
    input  logic signed [mhdset_pkg::DATA_WIDTH-1:0]         mag_four_z,
    input  logic signed [mhdset_pkg::DATA_WIDTH-1:0]         mag_sq,
    output logic                                             out_valid,
    input  logic                                             out_ready,
    output logic [mhdset_pkg::IDX_W-1:0]                     row_index,
    output logic [mhdset_pkg::IDX_W-1:0]                     col_index,
    output logic signed [mhdset_pkg::DATA_WIDTH-1:0]         tensor_value,
    output logic                                             last_component,
    input  logic                                             cfg_valid,
    output logic                                             cfg_ready,
    input  logic [mhdset_pkg::CFG_IDX_W-1:0]                 cfg_index,
    input  logic signed [mhdset_pkg::MET_WIDTH-1:0]          cfg_data
);

    localparam int DW = mhdset_pkg::DATA_WIDTH;
    localparam int MW = mhdset_pkg::MET_WIDTH;
    localparam int FB = mhdset_pkg::FRAC_BITS;
    localparam int SW = mhdset_pkg::SPLIT_W;
    localparam int CW = mhdset_pkg::COMP_W;
    localparam int IW = mhdset_pkg::IDX_W;

    // Metric registers.
    logic signed [MW-1:0] metric_t_reg;
    logic signed [MW-1:0] metric_x_reg;
    logic signed [MW-1:0] metric_y_reg;
    logic signed [MW-1:0] metric_z_reg;

    // Holding register for the item whose components are being issued.
    logic          hold_valid_reg;
    logic [CW-1:0] hold_k_reg;
    logic signed [DW-1:0] hold_rho_reg, hold_p_reg, hold_h_reg, hold_bsq_reg;
    logic signed [DW-1:0] hold_u0_reg, hold_u1_reg, hold_u2_reg, hold_u3_reg;
    logic signed [DW-1:0] hold_b0_reg, hold_b1_reg, hold_b2_reg, hold_b3_reg;

    logic adv;
    logic in_accept;
    logic issue_last;
    logic [IW-1:0] iss_i;
    logic [IW-1:0] iss_j;

    // Stage 1.
    logic                                        v1_reg;
    logic [CW-1:0]                               s1_k_reg, s1_k_next;
    logic signed [mhdset_pkg::PROD_W-1:0]        s1_rhoh_reg, s1_rhoh_next;
    logic signed [mhdset_pkg::PROD_W-1:0]        s1_bb_reg, s1_bb_next;
    logic signed [mhdset_pkg::PTOT_W-1:0]        s1_ptot_reg, s1_ptot_next;
    logic signed [DW-1:0]                        s1_bsq_reg, s1_bsq_next;
    logic signed [DW-1:0]                        s1_ui_reg, s1_ui_next;
    logic signed [DW-1:0]                        s1_uj_reg, s1_uj_next;
    logic signed [MW-1:0]                        s1_g_reg, s1_g_next;

    // Stage 2.
    logic                                        v2_reg;
    logic [CW-1:0]                               s2_k_reg;
    logic signed [mhdset_pkg::HTOT_W-1:0]        s2_htot_reg, s2_htot_next;
    logic signed [mhdset_pkg::T3_W-1:0]          s2_t3_reg, s2_t3_next;
    logic signed [mhdset_pkg::T2P_W-1:0]         s2_t2p_reg, s2_t2p_next;
    logic signed [DW-1:0]                        s2_ui_reg, s2_uj_reg;

    // Stage 3.
    logic                                        v3_reg;
    logic [CW-1:0]                               s3_k_reg;
    logic signed [mhdset_pkg::HP_HI_W-1:0]       s3_hphi_reg, s3_hphi_next;
    logic signed [mhdset_pkg::HP_LO_W-1:0]       s3_hplo_reg, s3_hplo_next;
    logic signed [mhdset_pkg::T2_W-1:0]          s3_t2_reg, s3_t2_next;
    logic signed [mhdset_pkg::T3_W-1:0]          s3_t3_reg;
    logic signed [DW-1:0]                        s3_uj_reg;

    // Stage 4.
    logic                                        v4_reg;
    logic [CW-1:0]                               s4_k_reg;
    logic signed [mhdset_pkg::HPF_W-1:0]         hpf;
    logic signed [mhdset_pkg::HU_W-1:0]          s4_hu_reg, s4_hu_next;
    logic signed [mhdset_pkg::T2_W-1:0]          s4_t2_reg;
    logic signed [mhdset_pkg::T3_W-1:0]          s4_t3_reg;
    logic signed [DW-1:0]                        s4_uj_reg;

    // Stage 5.
    logic                                        v5_reg;
    logic [CW-1:0]                               s5_k_reg;
    logic signed [mhdset_pkg::Q_HI_W-1:0]        s5_qhi_reg, s5_qhi_next;
    logic signed [mhdset_pkg::Q_LO_W-1:0]        s5_qlo_reg, s5_qlo_next;
    logic signed [mhdset_pkg::T2_W-1:0]          s5_t2_reg;
    logic signed [mhdset_pkg::T3_W-1:0]          s5_t3_reg;

    // Stage 6.
    logic                                        v6_reg;
    logic [CW-1:0]                               s6_k_reg;
    logic signed [mhdset_pkg::QF_W-1:0]          qf;
    logic signed [mhdset_pkg::T1W_W-1:0]         s6_t1w_reg, s6_t1w_next;
    logic signed [mhdset_pkg::T2_W-1:0]          s6_t2_reg;
    logic signed [mhdset_pkg::T3_W-1:0]          s6_t3_reg;

    // Stage 7.
    logic                                        v7_reg;
    logic [CW-1:0]                               s7_k_reg;
    logic signed [mhdset_pkg::T1_W-1:0]          s7_t1_reg, s7_t1_next;
    logic signed [mhdset_pkg::D_W-1:0]           s7_d_reg, s7_d_next;

    // Output register.
    logic                                        out_valid_reg;
    logic [IW-1:0]                               out_row_reg, out_col_reg;
    logic signed [DW-1:0]                        out_value_reg, out_value_next;
    logic                                        out_last_reg;
    logic signed [mhdset_pkg::V_W-1:0]           vsum;

    assign adv        = !out_valid_reg || out_ready;
    assign issue_last = hold_valid_reg && adv && (hold_k_reg == mhdset_pkg::COMP_LAST);
    assign in_ready   = !hold_valid_reg || issue_last;
    assign in_accept  = in_valid && in_ready;
    assign cfg_ready  = 1'b1;

    assign iss_i = hold_k_reg[CW-1:IW];
    assign iss_j = hold_k_reg[IW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            metric_t_reg <= mhdset_pkg::MET_NEG_ONE;
            metric_x_reg <= mhdset_pkg::MET_POS_ONE;
            metric_y_reg <= mhdset_pkg::MET_POS_ONE;
            metric_z_reg <= mhdset_pkg::MET_POS_ONE;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                mhdset_pkg::REG_METRIC_T: metric_t_reg <= cfg_data;
                mhdset_pkg::REG_METRIC_X: metric_x_reg <= cfg_data;
                mhdset_pkg::REG_METRIC_Y: metric_y_reg <= cfg_data;
                mhdset_pkg::REG_METRIC_Z: metric_z_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            hold_k_reg     <= '0;
        end
        else if (in_accept)
        begin
            hold_valid_reg <= 1'b1;
            hold_k_reg     <= '0;
        end
        else if (hold_valid_reg && adv)
        begin
            hold_k_reg <= hold_k_reg + CW'(1);
            if (hold_k_reg == mhdset_pkg::COMP_LAST)
            begin
                hold_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            hold_rho_reg <= rest_density;
            hold_p_reg   <= gas_pressure;
            hold_h_reg   <= specific_enthalpy;
            hold_bsq_reg <= mag_sq;
            hold_u0_reg  <= four_vel_t;
            hold_u1_reg  <= four_vel_x;
            hold_u2_reg  <= four_vel_y;
            hold_u3_reg  <= four_vel_z;
            hold_b0_reg  <= mag_four_t;
            hold_b1_reg  <= mag_four_x;
            hold_b2_reg  <= mag_four_y;
            hold_b3_reg  <= mag_four_z;
        end
    end

    always_comb
    begin
        logic signed [DW-1:0] bi;
        logic signed [DW-1:0] bj;
        bi = mhdset_pkg::pick_data(iss_i, hold_b0_reg, hold_b1_reg, hold_b2_reg, hold_b3_reg);
        bj = mhdset_pkg::pick_data(iss_j, hold_b0_reg, hold_b1_reg, hold_b2_reg, hold_b3_reg);
        s1_k_next    = hold_k_reg;
        s1_ui_next   = mhdset_pkg::pick_data(iss_i, hold_u0_reg, hold_u1_reg,
                                             hold_u2_reg, hold_u3_reg);
        s1_uj_next   = mhdset_pkg::pick_data(iss_j, hold_u0_reg, hold_u1_reg,
                                             hold_u2_reg, hold_u3_reg);
        s1_rhoh_next = mhdset_pkg::PROD_W'(hold_rho_reg) * mhdset_pkg::PROD_W'(hold_h_reg);
        s1_bb_next   = mhdset_pkg::PROD_W'(bi) * mhdset_pkg::PROD_W'(bj);
        s1_ptot_next = mhdset_pkg::PTOT_W'(hold_p_reg) + mhdset_pkg::PTOT_W'(hold_bsq_reg >>> 1);
        s1_bsq_next  = hold_bsq_reg;
        // Off-diagonal components carry a zero metric entry.
        if (iss_i == iss_j)
        begin
            s1_g_next = mhdset_pkg::pick_met(iss_i, metric_t_reg, metric_x_reg,
                                             metric_y_reg, metric_z_reg);
        end
        else
        begin
            s1_g_next = '0;
        end
    end

    always_comb
    begin
        s2_htot_next = mhdset_pkg::HTOT_W'(s1_rhoh_reg >>> FB)
                     + mhdset_pkg::HTOT_W'(s1_bsq_reg);
        s2_t3_next   = mhdset_pkg::T3_W'(s1_bb_reg >>> FB);
        s2_t2p_next  = mhdset_pkg::T2P_W'(s1_ptot_reg) * mhdset_pkg::T2P_W'(s1_g_reg);
    end

    always_comb
    begin
        s3_hphi_next = mhdset_pkg::HP_HI_W'($signed(s2_htot_reg[mhdset_pkg::HTOT_W-1:SW]))
                     * mhdset_pkg::HP_HI_W'(s2_ui_reg);
        s3_hplo_next = mhdset_pkg::HP_LO_W'($signed({1'b0, s2_htot_reg[SW-1:0]}))
                     * mhdset_pkg::HP_LO_W'(s2_ui_reg);
        s3_t2_next   = mhdset_pkg::T2_W'(s2_t2p_reg >>> FB);
    end

    always_comb
    begin
        hpf = (mhdset_pkg::HPF_W'(s3_hphi_reg) <<< SW) + mhdset_pkg::HPF_W'(s3_hplo_reg);
        s4_hu_next = mhdset_pkg::HU_W'(hpf >>> FB);
    end

    always_comb
    begin
        s5_qhi_next = mhdset_pkg::Q_HI_W'($signed(s4_hu_reg[mhdset_pkg::HU_W-1:SW]))
                    * mhdset_pkg::Q_HI_W'(s4_uj_reg);
        s5_qlo_next = mhdset_pkg::Q_LO_W'($signed({1'b0, s4_hu_reg[SW-1:0]}))
                    * mhdset_pkg::Q_LO_W'(s4_uj_reg);
    end

    always_comb
    begin
        qf = (mhdset_pkg::QF_W'(s5_qhi_reg) <<< SW) + mhdset_pkg::QF_W'(s5_qlo_reg);
        s6_t1w_next = mhdset_pkg::T1W_W'(qf >>> FB);
    end

    // A kinetic term beyond the limit saturates the result whatever the other terms are.
    always_comb
    begin
        if (s6_t1w_reg > mhdset_pkg::T1_HI)
        begin
            s7_t1_next = mhdset_pkg::T1_W'(mhdset_pkg::T1_HI);
        end
        else if (s6_t1w_reg < mhdset_pkg::T1_LO)
        begin
            s7_t1_next = mhdset_pkg::T1_W'(mhdset_pkg::T1_LO);
        end
        else
        begin
            s7_t1_next = mhdset_pkg::T1_W'(s6_t1w_reg);
        end
        s7_d_next = mhdset_pkg::D_W'(s6_t2_reg) - mhdset_pkg::D_W'(s6_t3_reg);
    end

    always_comb
    begin
        vsum = mhdset_pkg::V_W'(s7_t1_reg) + mhdset_pkg::V_W'(s7_d_reg);
        if (vsum > mhdset_pkg::OUT_MAX)
        begin
            out_value_next = DW'(mhdset_pkg::OUT_MAX);
        end
        else if (vsum < mhdset_pkg::OUT_MIN)
        begin
            out_value_next = DW'(mhdset_pkg::OUT_MIN);
        end
        else
        begin
            out_value_next = DW'(vsum);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            v6_reg        <= 1'b0;
            v7_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg        <= hold_valid_reg;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            v5_reg        <= v4_reg;
            v6_reg        <= v5_reg;
            v7_reg        <= v6_reg;
            out_valid_reg <= v7_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_k_reg    <= s1_k_next;
            s1_rhoh_reg <= s1_rhoh_next;
            s1_bb_reg   <= s1_bb_next;
            s1_ptot_reg <= s1_ptot_next;
            s1_bsq_reg  <= s1_bsq_next;
            s1_ui_reg   <= s1_ui_next;
            s1_uj_reg   <= s1_uj_next;
            s1_g_reg    <= s1_g_next;

            s2_k_reg    <= s1_k_reg;
            s2_htot_reg <= s2_htot_next;
            s2_t3_reg   <= s2_t3_next;
            s2_t2p_reg  <= s2_t2p_next;
            s2_ui_reg   <= s1_ui_reg;
            s2_uj_reg   <= s1_uj_reg;

            s3_k_reg    <= s2_k_reg;
            s3_hphi_reg <= s3_hphi_next;
            s3_hplo_reg <= s3_hplo_next;
            s3_t2_reg   <= s3_t2_next;
            s3_t3_reg   <= s2_t3_reg;
            s3_uj_reg   <= s2_uj_reg;

            s4_k_reg    <= s3_k_reg;
            s4_hu_reg   <= s4_hu_next;
            s4_t2_reg   <= s3_t2_reg;
            s4_t3_reg   <= s3_t3_reg;
            s4_uj_reg   <= s3_uj_reg;

            s5_k_reg    <= s4_k_reg;
            s5_qhi_reg  <= s5_qhi_next;
            s5_qlo_reg  <= s5_qlo_next;
            s5_t2_reg   <= s4_t2_reg;
            s5_t3_reg   <= s4_t3_reg;

            s6_k_reg    <= s5_k_reg;
            s6_t1w_reg  <= s6_t1w_next;
            s6_t2_reg   <= s5_t2_reg;
            s6_t3_reg   <= s5_t3_reg;

            s7_k_reg    <= s6_k_reg;
            s7_t1_reg   <= s7_t1_next;
            s7_d_reg    <= s7_d_next;

            out_row_reg   <= s7_k_reg[CW-1:IW];
            out_col_reg   <= s7_k_reg[IW-1:0];
            out_value_reg <= out_value_next;
            out_last_reg  <= (s7_k_reg == mhdset_pkg::COMP_LAST);
        end
    end

    assign out_valid      = out_valid_reg;
    assign row_index      = out_row_reg;
    assign col_index      = out_col_reg;
    assign tensor_value   = out_value_reg;
    assign last_component = out_last_reg;

    // An accepted item starts issuing from its first component.
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> hold_valid_reg && hold_k_reg == '0)
        else $error("accepted item does not start at its first component");

    // After the last component is issued with no new item, the holding register is free.
    a_issue_done: assert property (@(posedge clk) disable iff (!rst_n)
        issue_last && !in_valid |=> !hold_valid_reg)
        else $error("holding register still busy after last component");

    // A stall freezes every stage of the pipeline.
    a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable({v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg,
                          out_valid_reg}))
        else $error("pipeline moved during a stall");

    // The last-component flag marks only the bottom-right corner of the tensor.
    a_last_corner: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_component |-> row_index == 2'd3 && col_index == 2'd3)
        else $error("last component flag on a wrong position");

    // Metric registers change only through the configuration channel.
    a_metric_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(cfg_valid && cfg_ready) |=> $stable({metric_t_reg, metric_x_reg,
                                               metric_y_reg, metric_z_reg}))
        else $error("metric changed without a configuration write");

endmodule

@@ dv/mhd_tensor_checker.sv @@
`timescale 1ns / 1ps
// Watches the MHD tensor block, predicts the sixteen components of each cell and compares them.
module mhd_tensor_checker (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     in_valid,
    input  logic                                     in_ready,
    input  logic signed [mhdset_pkg::DATA_WIDTH-1:0] rest_density,
    input  logic signed [mhdset_pkg::DATA_WIDTH-1:0] gas_pressure,
    input  logic signed [mhdset_pkg::DATA_WIDTH-1:0] specific_enthalpy,
    input  logic signed [mhdset_pkg::DATA_WIDTH-1:0] four_vel_t,
    input  logic signed [mhdset_pkg::DATA_WIDTH-1:0] four_vel_x,
    input  logic signed [mhdset_pkg::DATA_WIDTH-1:0] four_vel_y,
    input  logic signed [mhdset_pkg::DATA_WIDTH-1:0] four_vel_z,
    input  logic signed [mhdset_pkg::DATA_WIDTH-1:0] mag_four_t,
    input  logic signed [mhdset_pkg::DATA_WIDTH-1:0] mag_four_x,
    input  logic signed [mhdset_pkg::DATA_WIDTH-1:0] mag_four_y,
    input  logic signed [mhdset_pkg::DATA_WIDTH-1:0] mag_four_z,
    input  logic signed [mhdset_pkg::DATA_WIDTH-1:0] mag_sq,
    input  logic                                     out_valid,
    input  logic                                     out_ready,
    input  logic [mhdset_pkg::IDX_W-1:0]             row_index,
    input  logic [mhdset_pkg::IDX_W-1:0]             col_index,
    input  logic signed [mhdset_pkg::DATA_WIDTH-1:0] tensor_value,
    input  logic                                     last_component,
    input  logic                                     cfg_valid,
    input  logic                                     cfg_ready,
    input  logic [mhdset_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic signed [mhdset_pkg::MET_WIDTH-1:0]  cfg_data,
    output int                                       fail_count,
    output int                                       pending
);

    localparam int DATA_WIDTH = mhdset_pkg::DATA_WIDTH;
    localparam int FRAC_BITS  = mhdset_pkg::FRAC_BITS;
    localparam int MET_WIDTH  = mhdset_pkg::MET_WIDTH;
    localparam int IDX_W      = mhdset_pkg::IDX_W;

    typedef logic signed [127:0] acc_t;

    typedef struct packed {
        logic [IDX_W-1:0]      row;
        logic [IDX_W-1:0]      col;
        logic [DATA_WIDTH-1:0] value;
        logic                  last;
    } component_t;

    localparam acc_t RANGE_LIM = acc_t'(1) <<< 62;
    localparam acc_t HALF_Q    = acc_t'(1) <<< (FRAC_BITS - 1);
    localparam acc_t WORD_MAX  = (acc_t'(1) <<< (DATA_WIDTH - 1)) - acc_t'(1);
    localparam acc_t WORD_MIN  = -WORD_MAX - acc_t'(1);

    logic signed [MET_WIDTH-1:0] metric [4];
    component_t                  tensor_due [$];

    function automatic acc_t clip_range(input acc_t v);
        if (v > RANGE_LIM)
            return RANGE_LIM;
        if (v < -RANGE_LIM)
            return -RANGE_LIM;
        return v;
    endfunction

    // Exact product, scaled down with rounding toward minus infinity and clipped to the range limit.
    function automatic acc_t fx_mul(input acc_t a, input acc_t b);
        acc_t prod;
        prod = a * b;
        return clip_range(prod >>> FRAC_BITS);
    endfunction

    task automatic expand_tensor();
        acc_t       u [4];
        acc_t       b [4];
        acc_t       p_tot;
        acc_t       h_tot;
        acc_t       hu;
        acc_t       t1;
        acc_t       t2;
        acc_t       t3;
        acc_t       v;
        component_t c;
        int         mu;
        int         nu;
        u[0] = four_vel_t;
        u[1] = four_vel_x;
        u[2] = four_vel_y;
        u[3] = four_vel_z;
        b[0] = mag_four_t;
        b[1] = mag_four_x;
        b[2] = mag_four_y;
        b[3] = mag_four_z;
        p_tot = clip_range(acc_t'(gas_pressure) + fx_mul(acc_t'(mag_sq), HALF_Q));
        h_tot = clip_range(fx_mul(acc_t'(rest_density), acc_t'(specific_enthalpy))
                           + acc_t'(mag_sq));
        for (mu = 0; mu < 4; mu++)
        begin
            hu = fx_mul(h_tot, u[mu]);
            for (nu = 0; nu < 4; nu++)
            begin
                t1 = fx_mul(hu, u[nu]);
                t2 = (mu == nu) ? fx_mul(p_tot, acc_t'(metric[mu])) : acc_t'(0);
                t3 = fx_mul(b[mu], b[nu]);
                v = clip_range(clip_range(t1 + t2) - t3);
                if (v > WORD_MAX)
                    v = WORD_MAX;
                else if (v < WORD_MIN)
                    v = WORD_MIN;
                c.row = IDX_W'(mu);
                c.col = IDX_W'(nu);
                c.value = v[DATA_WIDTH-1:0];
                c.last = (mu == 3 && nu == 3);
                tensor_due.push_back(c);
            end
        end
    endtask

    always @(negedge clk)
    begin : watch
        component_t want;
        if (!rst_n)
        begin
            metric[0] = mhdset_pkg::MET_NEG_ONE;
            metric[1] = mhdset_pkg::MET_POS_ONE;
            metric[2] = mhdset_pkg::MET_POS_ONE;
            metric[3] = mhdset_pkg::MET_POS_ONE;
            tensor_due.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                metric[cfg_index] = cfg_data;
            if (in_valid && in_ready)
                expand_tensor();
            if (out_valid && out_ready)
            begin
                if (tensor_due.size() == 0)
                begin
                    $error("unexpected tensor component: row %0d col %0d value %0d",
                           row_index, col_index, tensor_value);
                    fail_count++;
                end
                else
                begin
                    want = tensor_due.pop_front();
                    if (row_index !== want.row)
                    begin
                        $error("row_index: expected %0d actual %0d", want.row, row_index);
                        fail_count++;
                    end
                    if (col_index !== want.col)
                    begin
                        $error("col_index: expected %0d actual %0d", want.col, col_index);
                        fail_count++;
                    end
                    if (tensor_value !== want.value)
                    begin
                        $error("tensor_value: expected %0d actual %0d",
                               $signed(want.value), tensor_value);
                        fail_count++;
                    end
                    if (last_component !== want.last)
                    begin
                        $error("last_component: expected %0d actual %0d",
                               want.last, last_component);
                        fail_count++;
                    end
                end
            end
        end
        pending = tensor_due.size();
    end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// Testbench top for the MHD stress-energy tensor block: clock, reset, stimulus and verdict.
module tb_top;

    localparam int DATA_WIDTH = mhdset_pkg::DATA_WIDTH;
    localparam int FRAC_BITS  = mhdset_pkg::FRAC_BITS;
    localparam int MET_WIDTH  = mhdset_pkg::MET_WIDTH;
    localparam int IDX_W      = mhdset_pkg::IDX_W;

    typedef logic [11:0][DATA_WIDTH-1:0] cell_t;

    localparam int F_RHO  = 0;
    localparam int F_PRES = 1;
    localparam int F_ENTH = 2;
    localparam int F_UT   = 3;
    localparam int F_UX   = 4;
    localparam int F_UY   = 5;
    localparam int F_UZ   = 6;
    localparam int F_BT   = 7;
    localparam int F_BX   = 8;
    localparam int F_BY   = 9;
    localparam int F_BZ   = 10;
    localparam int F_BSQ  = 11;

    localparam logic [DATA_WIDTH-1:0] W_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] W_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam logic [DATA_WIDTH-1:0] W_ONE = DATA_WIDTH'(1) << FRAC_BITS;
    localparam logic [DATA_WIDTH-1:0] W_ULP = DATA_WIDTH'(1);
    localparam logic [DATA_WIDTH-1:0] W_NEG = {DATA_WIDTH{1'b1}};
    localparam int                    ITEMS_PER_PHASE = 50;
    localparam int                    HOLD_CYCLES     = 300;

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               in_valid = 1'b0;
    logic                               in_ready;
    logic signed [DATA_WIDTH-1:0]       rest_density = '0;
    logic signed [DATA_WIDTH-1:0]       gas_pressure = '0;
    logic signed [DATA_WIDTH-1:0]       specific_enthalpy = '0;
    logic signed [DATA_WIDTH-1:0]       four_vel_t = '0;
    logic signed [DATA_WIDTH-1:0]       four_vel_x = '0;
    logic signed [DATA_WIDTH-1:0]       four_vel_y = '0;
    logic signed [DATA_WIDTH-1:0]       four_vel_z = '0;
    logic signed [DATA_WIDTH-1:0]       mag_four_t = '0;
    logic signed [DATA_WIDTH-1:0]       mag_four_x = '0;
    logic signed [DATA_WIDTH-1:0]       mag_four_y = '0;
    logic signed [DATA_WIDTH-1:0]       mag_four_z = '0;
    logic signed [DATA_WIDTH-1:0]       mag_sq = '0;
    logic                               out_valid;
    logic                               out_ready = 1'b0;
    logic [IDX_W-1:0]                   row_index;
    logic [IDX_W-1:0]                   col_index;
    logic signed [DATA_WIDTH-1:0]       tensor_value;
    logic                               last_component;
    logic                               cfg_valid = 1'b0;
    logic                               cfg_ready;
    mhdset_pkg::cfg_reg_t               cfg_index = mhdset_pkg::REG_METRIC_T;
    logic signed [MET_WIDTH-1:0]        cfg_data = '0;

    int fail_count;
    int pending;
    int send_idle_pct = 6;
    int recv_idle_pct = 56;
    int hold_req = 0;

    mhd_stress_energy_tensor_top uut (.*);

    mhd_tensor_checker tensor_chk (.*);

    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("FAIL mhd_stress_energy_tensor_top");
        $finish;
    end

    initial
    begin : receiver
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (hold_seen != hold_req)
            begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    function automatic logic [DATA_WIDTH-1:0] fx_span(input int lo, input int hi);
        return DATA_WIDTH'(lo + int'($urandom_range(0, hi - lo)));
    endfunction

    function automatic logic [DATA_WIDTH-1:0] corner_word();
        case ($urandom_range(0, 5))
            0:       return W_MAX;
            1:       return W_MIN;
            2:       return '0;
            3:       return W_ULP;
            4:       return W_NEG;
            default: return W_ONE;
        endcase
    endfunction

    function automatic cell_t random_cell();
        cell_t c;
        int    pick;
        int    k;
        pick = $urandom_range(0, 99);
        if (pick < 60)
        begin
            c[F_RHO]  = fx_span(0, 4 * 65536);
            c[F_PRES] = fx_span(0, 2 * 65536);
            c[F_ENTH] = fx_span(65536, 3 * 65536);
            c[F_UT]   = fx_span(65536, 3 * 65536);
            for (k = F_UX; k <= F_UZ; k++)
                c[k] = fx_span(-2 * 65536, 2 * 65536);
            for (k = F_BT; k <= F_BZ; k++)
                c[k] = fx_span(-65536, 65536);
            c[F_BSQ]  = fx_span(0, 2 * 65536);
        end
        else if (pick < 85)
        begin
            for (k = 0; k < 12; k++)
                c[k] = $urandom;
        end
        else
        begin
            for (k = 0; k < 12; k++)
                c[k] = $urandom_range(0, 1) ? corner_word() : DATA_WIDTH'($urandom);
        end
        return c;
    endfunction

    function automatic logic signed [MET_WIDTH-1:0] random_metric();
        int v;
        v = int'($urandom_range(0, 131072)) - 65536;
        return v[MET_WIDTH-1:0];
    endfunction

    task automatic send_cell(input cell_t c);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid          <= 1'b1;
        rest_density      <= c[F_RHO];
        gas_pressure      <= c[F_PRES];
        specific_enthalpy <= c[F_ENTH];
        four_vel_t        <= c[F_UT];
        four_vel_x        <= c[F_UX];
        four_vel_y        <= c[F_UY];
        four_vel_z        <= c[F_UZ];
        mag_four_t        <= c[F_BT];
        mag_four_x        <= c[F_BX];
        mag_four_y        <= c[F_BY];
        mag_four_z        <= c[F_BZ];
        mag_sq            <= c[F_BSQ];
        do @(negedge clk); while (!in_ready);
        @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (12) @(posedge clk);
    endtask

    task automatic write_reg(input mhdset_pkg::cfg_reg_t r,
                             input logic signed [MET_WIDTH-1:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= r;
        cfg_data  <= d;
        do @(negedge clk); while (!cfg_ready);
        @(posedge clk);
    endtask

    task automatic load_metric(input logic signed [MET_WIDTH-1:0] gt,
                               input logic signed [MET_WIDTH-1:0] gx,
                               input logic signed [MET_WIDTH-1:0] gy,
                               input logic signed [MET_WIDTH-1:0] gz);
        write_reg(mhdset_pkg::REG_METRIC_T, gt);
        write_reg(mhdset_pkg::REG_METRIC_X, gx);
        write_reg(mhdset_pkg::REG_METRIC_Y, gy);
        write_reg(mhdset_pkg::REG_METRIC_Z, gz);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin : stimulus
        cell_t c;
        int    ph;
        int    k;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed cells under the reset metric.
        send_cell('0);
        send_cell({12{W_MAX}});
        send_cell({12{W_MIN}});
        send_cell({12{W_NEG}});
        send_cell({12{W_ULP}});
        send_cell({12{32'hAAAA_AAAA}});
        send_cell({12{32'h5555_5555}});
        c = '0;
        c[F_RHO] = W_ONE;
        c[F_ENTH] = W_ONE;
        c[F_PRES] = W_ONE >> 1;
        c[F_UT] = W_ONE;
        send_cell(c);
        // Tiny negative products must round down, and an odd negative b^2 halves downward.
        c = '0;
        c[F_RHO] = W_NEG;
        c[F_ENTH] = W_ULP;
        c[F_BSQ] = -DATA_WIDTH'(3);
        c[F_UT] = W_ONE;
        c[F_BX] = W_NEG;
        c[F_BY] = W_ULP;
        send_cell(c);
        c = '0;
        c[F_RHO] = W_MAX;
        c[F_ENTH] = W_MAX;
        for (k = F_UT; k <= F_UZ; k++)
            c[k] = W_MAX;
        send_cell(c);
        c = '0;
        for (k = F_BT; k <= F_BZ; k++)
            c[k] = W_MAX;
        send_cell(c);
        c[F_RHO] = W_MAX;
        c[F_ENTH] = W_MIN;
        c[F_PRES] = W_MIN;
        c[F_BSQ] = W_MAX;
        c[F_UT] = W_MAX;
        c[F_UX] = W_MIN;
        c[F_UY] = W_ONE;
        c[F_UZ] = -W_ONE;
        c[F_BT] = W_MIN;
        c[F_BX] = W_MAX;
        c[F_BY] = W_NEG;
        c[F_BZ] = W_ULP;
        send_cell(c);
        send_cell(random_cell());
        send_cell(random_cell());

        for (ph = 0; ph < 6; ph++)
        begin
            drain();
            case (ph)
                0: load_metric(mhdset_pkg::MET_NEG_ONE, mhdset_pkg::MET_NEG_ONE,
                               mhdset_pkg::MET_NEG_ONE, mhdset_pkg::MET_NEG_ONE);
                1: load_metric(mhdset_pkg::MET_POS_ONE, mhdset_pkg::MET_POS_ONE,
                               mhdset_pkg::MET_POS_ONE, mhdset_pkg::MET_POS_ONE);
                2: load_metric('0, -18'sd1, 18'sd1, '0);
                5: load_metric(mhdset_pkg::MET_NEG_ONE, mhdset_pkg::MET_POS_ONE,
                               mhdset_pkg::MET_POS_ONE, mhdset_pkg::MET_POS_ONE);
                default: load_metric(random_metric(), random_metric(),
                                     random_metric(), random_metric());
            endcase
            if (ph == 2)
            begin
                send_idle_pct = 56;
                recv_idle_pct = 6;
            end
            if (ph == 4)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
                hold_req <= hold_req + 1;
            end
            for (k = 0; k < ITEMS_PER_PHASE; k++)
                send_cell(random_cell());
        end

        drain();
        if (fail_count == 0)
            $display("PASS mhd_stress_energy_tensor_top");
        else
            $display("FAIL mhd_stress_energy_tensor_top");
        $finish;
    end

endmodule
